[design/uart_8n1_transceiver_unit_defines.svh]
// Assertion macros shared by the transceiver RTL.
`ifndef UART_8N1_TRANSCEIVER_UNIT_DEFINES_SVH
`define UART_8N1_TRANSCEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UART8N1_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define UART8N1_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/uart8n1_pkg.sv]
`default_nettype none
package uart8n1_pkg;

  localparam int TICK_BITS = 24;
  localparam int DATA_BITS = 8;
  localparam int IDX_BITS  = 4;

  localparam logic [TICK_BITS-1:0] CPB_RESET = TICK_BITS'(6076);

  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic [DATA_BITS-1:0] data_t;
  typedef logic [IDX_BITS-1:0]  idx_t;

  typedef enum logic [1:0] {
    RX_IDLE  = 2'd0,
    RX_WAIT  = 2'd1,
    RX_ALIGN = 2'd2,
    RX_BITS  = 2'd3
  } rx_phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_FRAME   = 2'd2
  } rx_status_t;

  typedef struct packed {
    logic line;
    logic busy;
  } tx_res_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] data;
    rx_status_t status;
  } rx_res_t;

endpackage
`default_nettype wire

[design/uart_8n1_transceiver_unit.sv]
`default_nettype none
`include "uart_8n1_transceiver_unit_defines.svh"
// 8N1 UART transceiver, one input beat per bit-timer tick. Each beat carries the
// sampled rx line plus optional send and receive-arm requests and yields exactly
// one result beat with the tx line, both busy flags and any receive completion.
// Throughput is one beat per cycle while out_ready is high; each beat passes
// the input register, then the result register. The tx and rx counters update
// once per beat. Write cycles_per_bit (cfg_wr_en/cfg_wr_data) only while no beat
// is in flight; it resets to 6076. A bit time of 0 or 1 gives one-tick bits.
module uart_8n1_transceiver_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [23:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_rx_line,
  input  wire logic        in_send_valid,
  input  wire logic [7:0]  in_send_byte,
  input  wire logic        in_receive_arm,
  input  wire logic [23:0] in_timeout_ticks,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_tx_line,
  output logic             out_tx_busy,
  output logic             out_rx_busy,
  output logic             out_rx_done,
  output logic [7:0]       out_rx_byte,
  output logic [1:0]       out_rx_status
);

  uart8n1_pkg::tick_t cpb_r;

  logic               in_valid_r;
  logic               in_rx_line_r;
  logic               in_send_valid_r;
  logic [7:0]         in_send_byte_r;
  logic               in_receive_arm_r;
  uart8n1_pkg::tick_t in_timeout_ticks_r;

  logic                 out_valid_r;
  uart8n1_pkg::tx_res_t tx_res_r;
  uart8n1_pkg::rx_res_t rx_res_r;

  uart8n1_pkg::tx_res_t tx_res;
  uart8n1_pkg::rx_res_t rx_res;
  logic                 advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpb_r <= uart8n1_pkg::CPB_RESET;
    end else if (cfg_wr_en) begin
      cpb_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_rx_line_r       <= in_rx_line;
      in_send_valid_r    <= in_send_valid;
      in_send_byte_r     <= in_send_byte;
      in_receive_arm_r   <= in_receive_arm;
      in_timeout_ticks_r <= in_timeout_ticks;
    end
  end

  uart8n1_tx u_tx (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .cycles_per_bit (cpb_r),
    .send_valid     (in_send_valid_r),
    .send_byte      (in_send_byte_r),
    .res            (tx_res)
  );

  uart8n1_rx u_rx (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (advance),
    .cycles_per_bit (cpb_r),
    .rx_line        (in_rx_line_r),
    .receive_arm    (in_receive_arm_r),
    .timeout_ticks  (in_timeout_ticks_r),
    .res            (rx_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx_res_r <= tx_res;
      rx_res_r <= rx_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tx_line   = tx_res_r.line;
  assign out_tx_busy   = tx_res_r.busy;
  assign out_rx_busy   = rx_res_r.busy;
  assign out_rx_done   = rx_res_r.done;
  assign out_rx_byte   = rx_res_r.data;
  assign out_rx_status = rx_res_r.status;

  `UART8N1_ASSERT_NOW(a_done_not_busy, out_valid_r && rx_res_r.done, !rx_res_r.busy,
    "receive reported done while still busy")
  `UART8N1_ASSERT_NOW(a_quiet_result, out_valid_r && !rx_res_r.done,
    (rx_res_r.status == uart8n1_pkg::ST_OK) && (rx_res_r.data == 8'd0),
    "status or byte set without done")
  `UART8N1_ASSERT_NOW(a_idle_line, out_valid_r && !tx_res_r.busy, tx_res_r.line,
    "tx line low while not busy")
  `UART8N1_ASSERT_NEXT(a_beat_kept, in_valid_r && !advance, in_valid_r,
    "input beat dropped before advance")

endmodule
`default_nettype wire

[design/uart8n1_tx.sv]
`default_nettype none
`include "uart_8n1_transceiver_unit_defines.svh"
module uart8n1_tx (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire uart8n1_pkg::tick_t    cycles_per_bit,
  input  wire logic                  send_valid,
  input  wire logic [7:0]            send_byte,
  output uart8n1_pkg::tx_res_t       res
);

  uart8n1_pkg::data_t tx_shift_r,   tx_shift_nxt;
  uart8n1_pkg::idx_t  tx_idx_r,     tx_idx_nxt;
  uart8n1_pkg::tick_t tx_cnt_r,     tx_cnt_nxt;
  logic               tx_level_r,   tx_level_nxt;
  logic               tx_active_r,  tx_active_nxt;

  uart8n1_pkg::tick_t cnt_inc;
  uart8n1_pkg::idx_t  idx_inc;
  uart8n1_pkg::idx_t  idx_dec;

  assign cnt_inc = tx_cnt_r + uart8n1_pkg::TICK_BITS'(1);
  assign idx_inc = tx_idx_r + uart8n1_pkg::IDX_BITS'(1);
  assign idx_dec = tx_idx_r;

  always_comb begin
    tx_shift_nxt  = tx_shift_r;
    tx_idx_nxt    = tx_idx_r;
    tx_cnt_nxt    = tx_cnt_r;
    tx_level_nxt  = tx_level_r;
    tx_active_nxt = tx_active_r;
    if (!tx_active_r) begin
      if (send_valid) begin
        tx_active_nxt = 1'b1;
        tx_shift_nxt  = uart8n1_pkg::data_t'(send_byte);
        tx_idx_nxt    = '0;
        tx_cnt_nxt    = '0;
        tx_level_nxt  = 1'b0;
      end
    end else if (cnt_inc < cycles_per_bit) begin
      tx_cnt_nxt = cnt_inc;
    end else begin
      tx_cnt_nxt = '0;
      tx_idx_nxt = idx_inc;
      if (idx_inc >= uart8n1_pkg::IDX_BITS'(uart8n1_pkg::DATA_BITS + 2)) begin
        tx_active_nxt = 1'b0;
        tx_idx_nxt    = '0;
        tx_level_nxt  = 1'b1;
      end else if (idx_inc == uart8n1_pkg::IDX_BITS'(uart8n1_pkg::DATA_BITS + 1)) begin
        tx_level_nxt = 1'b1;
      end else begin
        // data bit k goes out at index k+1, so the select uses the old index
        tx_level_nxt = tx_shift_r[idx_dec[$clog2(uart8n1_pkg::DATA_BITS)-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_shift_r  <= '0;
      tx_idx_r    <= '0;
      tx_cnt_r    <= '0;
      tx_level_r  <= 1'b1;
      tx_active_r <= 1'b0;
    end else if (step) begin
      tx_shift_r  <= tx_shift_nxt;
      tx_idx_r    <= tx_idx_nxt;
      tx_cnt_r    <= tx_cnt_nxt;
      tx_level_r  <= tx_level_nxt;
      tx_active_r <= tx_active_nxt;
    end
  end

  assign res.line = tx_level_nxt;
  assign res.busy = tx_active_nxt;

  `UART8N1_ASSERT_NOW(a_tx_idle_high, !tx_active_r, tx_level_r,
    "tx line low while transmitter idle")
  `UART8N1_ASSERT_NOW(a_tx_idx_range, 1'b1,
    tx_idx_r <= uart8n1_pkg::IDX_BITS'(uart8n1_pkg::DATA_BITS + 1),
    "tx bit index past stop bit")
  `UART8N1_ASSERT_NEXT(a_tx_hold, !step, $stable(tx_active_r) && $stable(tx_cnt_r),
    "tx state moved without a beat")

endmodule
`default_nettype wire

[design/uart8n1_rx.sv]
`default_nettype none
`include "uart_8n1_transceiver_unit_defines.svh"
module uart8n1_rx (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire uart8n1_pkg::tick_t    cycles_per_bit,
  input  wire logic                  rx_line,
  input  wire logic                  receive_arm,
  input  wire uart8n1_pkg::tick_t    timeout_ticks,
  output uart8n1_pkg::rx_res_t       res
);

  uart8n1_pkg::rx_phase_t phase_r, phase_nxt;
  uart8n1_pkg::data_t     rx_shift_r, rx_shift_nxt;
  uart8n1_pkg::idx_t      rx_idx_r,   rx_idx_nxt;
  uart8n1_pkg::tick_t     rx_cnt_r,   rx_cnt_nxt;

  uart8n1_pkg::tick_t cnt_inc;
  uart8n1_pkg::tick_t wait_cnt;
  uart8n1_pkg::tick_t half_bit;
  logic               watching;
  logic               sample_due;
  logic               time_out;
  logic               stop_seen;

  assign cnt_inc    = rx_cnt_r + uart8n1_pkg::TICK_BITS'(1);
  assign wait_cnt   = (phase_r == uart8n1_pkg::RX_IDLE) ? timeout_ticks : rx_cnt_r;
  assign half_bit   = cycles_per_bit >> 1;
  assign watching   = (phase_r == uart8n1_pkg::RX_WAIT) ||
                      ((phase_r == uart8n1_pkg::RX_IDLE) && receive_arm);
  assign time_out   = watching && rx_line && (wait_cnt == '0);
  assign sample_due = (phase_r == uart8n1_pkg::RX_BITS) && !(cnt_inc < cycles_per_bit);
  assign stop_seen  = sample_due &&
                      !(rx_idx_r < uart8n1_pkg::IDX_BITS'(uart8n1_pkg::DATA_BITS));

  always_comb begin
    phase_nxt    = phase_r;
    rx_shift_nxt = rx_shift_r;
    rx_idx_nxt   = rx_idx_r;
    rx_cnt_nxt   = rx_cnt_r;
    unique case (phase_r)
      uart8n1_pkg::RX_IDLE, uart8n1_pkg::RX_WAIT: begin
        if (watching) begin
          if (!rx_line) begin
            phase_nxt    = uart8n1_pkg::RX_ALIGN;
            rx_cnt_nxt   = '0;
            rx_idx_nxt   = '0;
            rx_shift_nxt = '0;
          end else if (wait_cnt == '0) begin
            phase_nxt  = uart8n1_pkg::RX_IDLE;
            rx_cnt_nxt = wait_cnt;
          end else begin
            phase_nxt  = uart8n1_pkg::RX_WAIT;
            rx_cnt_nxt = wait_cnt - uart8n1_pkg::TICK_BITS'(1);
          end
        end
      end
      uart8n1_pkg::RX_ALIGN: begin
        if (cnt_inc >= half_bit) begin
          phase_nxt  = uart8n1_pkg::RX_BITS;
          rx_cnt_nxt = '0;
        end else begin
          rx_cnt_nxt = cnt_inc;
        end
      end
      uart8n1_pkg::RX_BITS: begin
        if (!sample_due) begin
          rx_cnt_nxt = cnt_inc;
        end else if (!stop_seen) begin
          rx_cnt_nxt   = '0;
          rx_shift_nxt = {rx_line, rx_shift_r[uart8n1_pkg::DATA_BITS-1:1]};
          rx_idx_nxt   = rx_idx_r + uart8n1_pkg::IDX_BITS'(1);
        end else begin
          rx_cnt_nxt = '0;
          phase_nxt  = uart8n1_pkg::RX_IDLE;
          rx_idx_nxt = '0;
        end
      end
      default: phase_nxt = uart8n1_pkg::RX_IDLE;
    endcase
  end

  always_comb begin
    res.busy   = (phase_nxt != uart8n1_pkg::RX_IDLE);
    res.done   = time_out || stop_seen;
    res.data   = '0;
    res.status = uart8n1_pkg::ST_OK;
    if (time_out) begin
      res.status = uart8n1_pkg::ST_TIMEOUT;
    end else if (stop_seen) begin
      if (rx_line) begin
        res.data = 8'(rx_shift_r);
      end else begin
        res.status = uart8n1_pkg::ST_FRAME;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= uart8n1_pkg::RX_IDLE;
      rx_shift_r <= '0;
      rx_idx_r   <= '0;
      rx_cnt_r   <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      rx_shift_r <= rx_shift_nxt;
      rx_idx_r   <= rx_idx_nxt;
      rx_cnt_r   <= rx_cnt_nxt;
    end
  end

  `UART8N1_ASSERT_NOW(a_rx_idx_zero, phase_r != uart8n1_pkg::RX_BITS, rx_idx_r == '0,
    "rx bit index nonzero outside data phase")
  `UART8N1_ASSERT_NOW(a_rx_idx_range, 1'b1,
    rx_idx_r <= uart8n1_pkg::IDX_BITS'(uart8n1_pkg::DATA_BITS),
    "rx bit index past stop bit")
  `UART8N1_ASSERT_NOW(a_rx_done_one, 1'b1, !(time_out && stop_seen),
    "timeout and stop check in the same beat")

endmodule
`default_nettype wire
